FILE: rtl/core/xcpf_pkg.sv
// ----------------------------------------------------------------------------
// xcpf_pkg
// Shared types, register codes and helpers for the XOR checksum framer.
// ----------------------------------------------------------------------------
package xcpf_pkg;

  localparam int BYTE_W    = 8;
  localparam int CFG_IDX_W = 2;

  typedef logic [BYTE_W-1:0] byte_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START = 2'd0,
    REG_SEP   = 2'd1,
    REG_CKSUM = 2'd2,
    REG_END   = 2'd3
  } reg_idx_t;

  // Reset values of the marks: '^' ',' '*' '$'
  localparam byte_t START_RST = 8'h5E;
  localparam byte_t SEP_RST   = 8'h2C;
  localparam byte_t CKSUM_RST = 8'h2A;
  localparam byte_t END_RST   = 8'h24;

  typedef struct packed {
    byte_t start_mark;
    byte_t separator_mark;
    byte_t checksum_mark;
    byte_t end_mark;
  } marks_t;

  // What follows the payload byte of one item
  typedef enum logic [1:0] {
    KIND_PLAIN   = 2'd0,
    KIND_SEP     = 2'd1,
    KIND_TRAILER = 2'd2
  } cmd_kind_t;

  // One classified item, front to back
  typedef struct packed {
    logic      start;  // open a frame with the start mark
    byte_t     data;
    cmd_kind_t kind;
    byte_t     sum;    // final checksum, meaningful for the trailer only
  } cmd_t;

  // Upper-case ASCII hex digit of a nibble
  function automatic byte_t hex_digit(input logic [3:0] nib);
    byte_t r;
    if (nib < 4'd10) begin
      r = 8'h30 + {4'h0, nib};
    end else begin
      r = 8'h41 + {4'h0, nib} - 8'd10;
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/xcpf_in_if.sv
// ----------------------------------------------------------------------------
// xcpf_in_if
// Input channel: one payload byte with field and frame end flags per beat.
// ----------------------------------------------------------------------------
interface xcpf_in_if;
  import xcpf_pkg::*;

  logic  valid;
  logic  ready;
  byte_t data_byte;
  logic  field_end;
  logic  frame_end;

  modport source (output valid, output data_byte, output field_end, output frame_end,
                  input ready);
  modport sink   (input valid, input data_byte, input field_end, input frame_end,
                  output ready);
endinterface

FILE: rtl/core/xcpf_out_if.sv
// ----------------------------------------------------------------------------
// xcpf_out_if
// Output channel: one framed byte per beat with last and frame done flags.
// ----------------------------------------------------------------------------
interface xcpf_out_if;
  import xcpf_pkg::*;

  logic  valid;
  logic  ready;
  byte_t out_byte;
  logic  run_last;
  logic  frame_done;

  modport source (output valid, output out_byte, output run_last, output frame_done,
                  input ready);
  modport sink   (input valid, input out_byte, input run_last, input frame_done,
                  output ready);
endinterface

FILE: rtl/core/xcpf_front.sv
// ----------------------------------------------------------------------------
// xcpf_front
// Accepts input beats, tracks frame state and the running XOR, and turns
// each beat into a command for the back end.
// ----------------------------------------------------------------------------
module xcpf_front (
  input  logic            clk,
  input  logic            rst,
  xcpf_in_if.sink         din,
  input  xcpf_pkg::byte_t separator_mark,
  input  logic            full,
  output logic            push,
  output xcpf_pkg::cmd_t  cmd
);
  import xcpf_pkg::*;

  logic  inside_frame;
  logic  inside_frame_next;
  byte_t running_xor;
  byte_t running_xor_next;
  byte_t xor_data;

  assign din.ready = !full;
  assign push      = din.valid && !full;

  // Classify the beat
  assign xor_data  = running_xor ^ din.data_byte;
  assign cmd.start = !inside_frame;
  assign cmd.data  = din.data_byte;
  assign cmd.sum   = xor_data;
  always_comb begin
    if (din.frame_end) begin
      cmd.kind = KIND_TRAILER;
    end else if (din.field_end) begin
      cmd.kind = KIND_SEP;
    end else begin
      cmd.kind = KIND_PLAIN;
    end
  end

  // Frame state update on accept
  always_comb begin
    inside_frame_next = inside_frame;
    running_xor_next  = running_xor;
    if (push) begin
      unique case (cmd.kind)
        KIND_TRAILER: begin
          inside_frame_next = 1'b0;
          running_xor_next  = '0;
        end
        KIND_SEP: begin
          inside_frame_next = 1'b1;
          running_xor_next  = xor_data ^ separator_mark;
        end
        default: begin
          inside_frame_next = 1'b1;
          running_xor_next  = xor_data;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inside_frame <= 1'b0;
      running_xor  <= '0;
    end else begin
      inside_frame <= inside_frame_next;
      running_xor  <= running_xor_next;
    end
  end

  // A trailer closes the frame and clears the checksum
  a_trailer_closes: assert property (@(posedge clk) disable iff (rst)
    push && (cmd.kind == KIND_TRAILER) |=> !inside_frame && (running_xor == '0))
    else $error("frame still open after trailer");

endmodule

FILE: rtl/core/xcpf_queue.sv
// ----------------------------------------------------------------------------
// xcpf_queue
// Small command FIFO between the front and back ends.
// ----------------------------------------------------------------------------
module xcpf_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  xcpf_pkg::cmd_t wr_cmd,
  input  logic           pop,
  output xcpf_pkg::cmd_t head,
  output logic           full,
  output logic           empty
);
  import xcpf_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_cmd;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full && !pop))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && empty))
    else $error("pop from empty queue");

endmodule

FILE: rtl/core/xcpf_back.sv
// ----------------------------------------------------------------------------
// xcpf_back
// Expands each command into its output beats, one per cycle while the output
// is ready, through a registered output stage.
// ----------------------------------------------------------------------------
module xcpf_back (
  input  logic             clk,
  input  logic             rst,
  input  xcpf_pkg::cmd_t   head,
  input  logic             empty,
  input  xcpf_pkg::marks_t marks,
  output logic             pop,
  xcpf_out_if.source       dout
);
  import xcpf_pkg::*;

  typedef enum logic [7:0] {
    PH_HEAD  = 8'b0000_0001,
    PH_START = 8'b0000_0010,
    PH_DATA  = 8'b0000_0100,
    PH_SEP   = 8'b0000_1000,
    PH_CK    = 8'b0001_0000,
    PH_HI    = 8'b0010_0000,
    PH_LO    = 8'b0100_0000,
    PH_END   = 8'b1000_0000
  } phase_t;

  phase_t phase;
  phase_t phase_next;
  phase_t cur_ph;
  phase_t adv_ph;
  byte_t  beat_byte;
  logic   beat_last;
  logic   beat_done;
  logic   load;
  logic   ovalid;
  byte_t  obyte;
  logic   olast;
  logic   odone;

  // Beat to emit now: the first beat of a command depends on its start flag
  always_comb begin
    if (phase == PH_HEAD) begin
      cur_ph = head.start ? PH_START : PH_DATA;
    end else begin
      cur_ph = phase;
    end
  end

  // Beat decode
  always_comb begin
    beat_byte = head.data;
    beat_last = 1'b0;
    beat_done = 1'b0;
    adv_ph    = PH_HEAD;
    unique case (cur_ph)
      PH_START: begin
        beat_byte = marks.start_mark;
        adv_ph    = PH_DATA;
      end
      PH_DATA: begin
        beat_byte = head.data;
        case (head.kind)
          KIND_SEP:     adv_ph = PH_SEP;
          KIND_TRAILER: adv_ph = PH_CK;
          default:      beat_last = 1'b1;
        endcase
      end
      PH_SEP: begin
        beat_byte = marks.separator_mark;
        beat_last = 1'b1;
      end
      PH_CK: begin
        beat_byte = marks.checksum_mark;
        adv_ph    = PH_HI;
      end
      PH_HI: begin
        beat_byte = hex_digit(head.sum[7:4]);
        adv_ph    = PH_LO;
      end
      PH_LO: begin
        beat_byte = hex_digit(head.sum[3:0]);
        adv_ph    = PH_END;
      end
      PH_END: begin
        beat_byte = marks.end_mark;
        beat_last = 1'b1;
        beat_done = 1'b1;
      end
      default: begin
        beat_last = 1'b1;
      end
    endcase
  end

  // Load the output register whenever a command waits and the register is free or being drained
  assign load       = !empty && (!ovalid || dout.ready);
  assign pop        = load && beat_last;
  assign phase_next = load ? (beat_last ? PH_HEAD : adv_ph) : phase;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_HEAD;
      ovalid <= 1'b0;
    end else begin
      phase <= phase_next;
      if (load) begin
        ovalid <= 1'b1;
      end else if (dout.ready) begin
        ovalid <= 1'b0;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (load) begin
      obyte <= beat_byte;
      olast <= beat_last;
      odone <= beat_done;
    end
  end

  assign dout.valid      = ovalid;
  assign dout.out_byte   = obyte;
  assign dout.run_last   = olast;
  assign dout.frame_done = odone;

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    ovalid && odone |-> olast)
    else $error("frame done on a beat that is not last");

endmodule

FILE: rtl/core/xor_checksum_packet_framer.sv
// Path: an accepted item is written into the command queue, then expanded into the registered output.
// Throughput: one output beat per cycle from the expander while dout.ready is high; an item makes 1 to 6
//   output beats (start mark, byte, separator or 4-byte trailer).
// Input takes one beat per cycle while the command queue (QUEUE_DEPTH) has room.
// Reset: marks return to '^' ',' '*' '$', no frame open, checksum zero, queue empty.
// ----------------------------------------------------------------------------
// xor_checksum_packet_framer
// Top level: mark registers, classifying front end, command queue and beat
// expander with a registered output.
// ----------------------------------------------------------------------------
module xor_checksum_packet_framer #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  xcpf_in_if.sink                          din,
  xcpf_out_if.source                       dout,
  input  logic                             cfg_wr_en,
  input  logic [xcpf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  xcpf_pkg::byte_t                  cfg_wdata
);
  import xcpf_pkg::*;

  marks_t marks;
  cmd_t   wr_cmd;
  cmd_t   head;
  logic   push;
  logic   pop;
  logic   full;
  logic   empty;

  // Mark registers
  always_ff @(posedge clk) begin
    if (rst) begin
      marks.start_mark     <= START_RST;
      marks.separator_mark <= SEP_RST;
      marks.checksum_mark  <= CKSUM_RST;
      marks.end_mark       <= END_RST;
    end else if (cfg_wr_en) begin
      unique case (reg_idx_t'(cfg_index))
        REG_START: marks.start_mark     <= cfg_wdata;
        REG_SEP:   marks.separator_mark <= cfg_wdata;
        REG_CKSUM: marks.checksum_mark  <= cfg_wdata;
        REG_END:   marks.end_mark       <= cfg_wdata;
        default:   ;
      endcase
    end
  end

  xcpf_front u_front (
    .clk            (clk),
    .rst            (rst),
    .din            (din),
    .separator_mark (marks.separator_mark),
    .full           (full),
    .push           (push),
    .cmd            (wr_cmd)
  );

  xcpf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_cmd (wr_cmd),
    .pop    (pop),
    .head   (head),
    .full   (full),
    .empty  (empty)
  );

  xcpf_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .empty (empty),
    .marks (marks),
    .pop   (pop),
    .dout  (dout)
  );

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the XOR checksum packet framer.
// A queue-fed driver sends payload beats with field and frame end flags, a
// scoreboard model frames each accepted beat into the bytes it must produce,
// and a monitor compares every output beat in order. Mark registers are
// reprogrammed between phases, including the all-zero and all-ones extremes.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import xcpf_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 100;
  localparam int PHASE_ITEMS  = 42;
  localparam int NUM_PHASES   = 5;
  localparam int MAX_REPORTS  = 50;

  typedef struct packed {
    byte_t data;
    logic  fld_end;
    logic  frm_end;
  } payload_item_t;

  typedef struct packed {
    byte_t value;
    logic  last;
    logic  done;
  } framed_beat_t;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  byte_t cfg_wdata;

  xcpf_in_if  din ();
  xcpf_out_if dout ();

  xor_checksum_packet_framer dut (
    .clk       (clk),
    .rst       (rst),
    .din       (din),
    .dout      (dout),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Stimulus and expected output
  payload_item_t pending_items[$];
  framed_beat_t  expected_beats[$];

  // Framer model state
  marks_t mark_shadow = '{START_RST, SEP_RST, CKSUM_RST, END_RST};
  logic   frame_open  = 1'b0;
  byte_t  running_sum = '0;

  // Run control and bookkeeping
  bit no_idle        = 1'b0;
  bit pressure_armed = 1'b0;
  bit pressure_done  = 1'b0;
  int in_gap         = 0;
  int out_gap        = 0;
  int hold_left      = 0;
  int stall_cycles   = 0;
  int err_count      = 0;
  int items_taken    = 0;
  int beats_seen     = 0;
  int frames_closed  = 0;
  int settings_used  = 1;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Upper-case ASCII hex digit of one nibble
  function automatic byte_t ascii_hex(logic [3:0] nib);
    if (nib < 4'd10) begin
      return byte_t'(8'h30 + nib);
    end
    return byte_t'(8'h37 + nib);
  endfunction

  function automatic void expect_beat(byte_t value, logic last, logic done);
    expected_beats.push_back('{value, last, done});
  endfunction

  // Frame one payload beat into the output bytes it causes
  function automatic void frame_item(payload_item_t it);
    byte_t sum;
    if (!frame_open) begin
      expect_beat(mark_shadow.start_mark, 1'b0, 1'b0);
      frame_open = 1'b1;
    end
    expect_beat(it.data, !(it.frm_end || it.fld_end), 1'b0);
    running_sum ^= it.data;
    if (it.frm_end) begin
      sum = running_sum;
      expect_beat(mark_shadow.checksum_mark, 1'b0, 1'b0);
      expect_beat(ascii_hex(sum[7:4]), 1'b0, 1'b0);
      expect_beat(ascii_hex(sum[3:0]), 1'b0, 1'b0);
      expect_beat(mark_shadow.end_mark, 1'b1, 1'b1);
      frame_open  = 1'b0;
      running_sum = '0;
    end else if (it.fld_end) begin
      expect_beat(mark_shadow.separator_mark, 1'b1, 1'b0);
      running_sum ^= mark_shadow.separator_mark;
    end
  endfunction

  function automatic void queue_item(byte_t data, logic fld_end, logic frm_end);
    pending_items.push_back('{data, fld_end, frm_end});
  endfunction

  // Mostly random bytes, with marks and extremes mixed in as payload
  function automatic byte_t pick_payload();
    case ($urandom_range(0, 15))
      0: return mark_shadow.separator_mark;
      1: return mark_shadow.start_mark;
      2: return mark_shadow.end_mark;
      3: return 8'h00;
      4: return 8'hFF;
      default: return byte_t'($urandom_range(0, 255));
    endcase
  endfunction

  // Well-formed frames with random fields, plus single beats of noise
  task automatic queue_random(int count);
    int left;
    int len;
    int k;
    left = count;
    while (left > 0) begin
      if ($urandom_range(0, 9) < 8) begin
        len = $urandom_range(1, 8);
        if (len > left) len = left;
        for (k = 0; k < len; k++) begin
          if (k == len - 1) begin
            queue_item(pick_payload(), 1'($urandom_range(0, 1)), 1'b1);
          end else begin
            queue_item(pick_payload(), $urandom_range(0, 2) == 0, 1'b0);
          end
        end
      end else begin
        len = 1;
        queue_item(pick_payload(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
      left -= len;
    end
  endtask

  task automatic program_mark(reg_idx_t idx, byte_t value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      REG_START: mark_shadow.start_mark     = value;
      REG_SEP:   mark_shadow.separator_mark = value;
      REG_CKSUM: mark_shadow.checksum_mark  = value;
      REG_END:   mark_shadow.end_mark       = value;
      default: ;
    endcase
  endtask

  // Block until nothing is queued, offered or outstanding
  task automatic wait_drained();
    @(negedge clk);
    while (pending_items.size() != 0 || din.valid || expected_beats.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // Input driver: holds a beat until taken, then waits a drawn gap
  always @(posedge clk) begin
    payload_item_t it;
    logic stalled;
    if (rst) begin
      din.valid <= 1'b0;
      in_gap = 0;
    end else begin
      stalled = din.valid && !din.ready;
      if (din.valid && din.ready) begin
        frame_item('{din.data_byte, din.field_end, din.frame_end});
        items_taken++;
        in_gap = no_idle ? 0 : $urandom_range(0, 4);
      end
      if (!stalled) begin
        if (in_gap > 0) begin
          in_gap--;
          din.valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          it = pending_items.pop_front();
          din.valid     <= 1'b1;
          din.data_byte <= it.data;
          din.field_end <= it.fld_end;
          din.frame_end <= it.frm_end;
        end else begin
          din.valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: checks each beat in order and throttles ready
  always @(posedge clk) begin
    framed_beat_t want;
    if (rst) begin
      dout.ready <= 1'b0;
      out_gap = 0;
    end else begin
      if (dout.valid && dout.ready) begin
        beats_seen++;
        if (expected_beats.size() == 0) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display("%0t: unexpected beat, expected none, got out_byte %02h", $time,
                     dout.out_byte);
        end else begin
          want = expected_beats.pop_front();
          if (dout.out_byte !== want.value) begin
            err_count++;
            if (err_count <= MAX_REPORTS)
              $display("%0t: out_byte mismatch, expected %02h, got %02h", $time,
                       want.value, dout.out_byte);
          end
          if (dout.run_last !== want.last) begin
            err_count++;
            if (err_count <= MAX_REPORTS)
              $display("%0t: run_last mismatch, expected %b, got %b", $time,
                       want.last, dout.run_last);
          end
          if (dout.frame_done !== want.done) begin
            err_count++;
            if (err_count <= MAX_REPORTS)
              $display("%0t: frame_done mismatch, expected %b, got %b", $time,
                       want.done, dout.frame_done);
          end
          if (want.done) frames_closed++;
        end
        out_gap = no_idle ? 0 : $urandom_range(0, 4);
      end
      // one long hold-off so the input side backs up
      if (pressure_armed && !pressure_done) begin
        pressure_done = 1'b1;
        hold_left     = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        dout.ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        dout.ready <= 1'b0;
      end else begin
        dout.ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if (!rst) begin
      if ((din.valid && din.ready) || (dout.valid && dout.ready) || cfg_wr_en) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
        $display("tb failed");
        $finish;
      end
    end
  end

  // Main sequence: reset, directed frames, then one random phase per setting
  initial begin
    marks_t phase_marks [NUM_PHASES];
    int ph;

    rst           = 1'b1;
    cfg_wr_en     = 1'b0;
    cfg_index     = '0;
    cfg_wdata     = '0;
    din.valid     = 1'b0;
    din.data_byte = '0;
    din.field_end = 1'b0;
    din.frame_end = 1'b0;
    dout.ready    = 1'b0;

    phase_marks[0] = '{8'h00, 8'h00, 8'h00, 8'h00};
    phase_marks[1] = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
    phase_marks[2] = '{byte_t'($urandom_range(0, 255)), byte_t'($urandom_range(0, 255)),
                       byte_t'($urandom_range(0, 255)), byte_t'($urandom_range(0, 255))};
    // marks that look like hex digits of the checksum
    phase_marks[3] = '{8'h30, 8'h41, 8'h46, 8'h39};
    phase_marks[4] = '{START_RST, SEP_RST, CKSUM_RST, END_RST};

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed frames under reset marks
    @(negedge clk);
    queue_item(8'h00, 1'b0, 1'b1);          // one-byte frame, checksum 00
    queue_item(8'hFF, 1'b0, 1'b1);          // checksum FF
    queue_item(8'h41, 1'b1, 1'b0);
    queue_item(8'h42, 1'b1, 1'b0);
    queue_item(8'h43, 1'b1, 1'b1);          // field and frame end together
    queue_item(SEP_RST, 1'b1, 1'b0);        // separator sent as payload
    queue_item(SEP_RST, 1'b0, 1'b0);
    queue_item(8'h09, 1'b0, 1'b1);
    queue_item(8'hA5, 1'b0, 1'b0);
    queue_item(8'h5A, 1'b1, 1'b0);
    queue_item(8'h3C, 1'b0, 1'b1);
    queue_item(8'h80, 1'b1, 1'b0);
    queue_item(8'h01, 1'b0, 1'b0);
    queue_item(8'h7F, 1'b1, 1'b1);
    queue_item(8'h9A, 1'b0, 1'b1);          // digit then letter
    queue_item(8'hA9, 1'b0, 1'b1);          // letter then digit
    queue_item(8'h0A, 1'b0, 1'b1);
    queue_item(8'hF0, 1'b1, 1'b0);
    queue_item(START_RST, 1'b0, 1'b0);      // marks as payload
    queue_item(END_RST, 1'b0, 1'b0);
    queue_item(8'h55, 1'b0, 1'b1);
    wait_drained();

    // Random phases, marks reprogrammed while idle
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      repeat (4) @(posedge clk);
      program_mark(REG_START, phase_marks[ph].start_mark);
      program_mark(REG_SEP,   phase_marks[ph].separator_mark);
      program_mark(REG_CKSUM, phase_marks[ph].checksum_mark);
      program_mark(REG_END,   phase_marks[ph].end_mark);
      @(posedge clk);
      cfg_wr_en <= 1'b0;
      settings_used++;
      @(negedge clk);
      no_idle = (ph == 1);
      queue_random(PHASE_ITEMS);
      if (ph == 2) pressure_armed = 1'b1;
      wait_drained();
    end

    repeat (8) @(posedge clk);
    $display("Framed %0d payload beats into %0d output beats, %0d frames closed.",
             items_taken, beats_seen, frames_closed);
    $display("Covered %0d mark settings, a no-idle phase and a %0d-cycle output hold-off.",
             settings_used, HOLD_CYCLES);
    if (err_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
